>>> sv/midpoint_circle_rasterizer_defines.svh
// assertion macros for the midpoint circle rasterizer
// used by the top level only; expects clk_i and rst_ni in scope
`ifndef MIDPOINT_CIRCLE_RASTERIZER_DEFINES_SVH
`define MIDPOINT_CIRCLE_RASTERIZER_DEFINES_SVH
`ifndef ASSERT_OFF
`define MCR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define MCR_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define MCR_ASSERT(lbl, prop, msg)
`define MCR_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

>>> sv/mcr_pkg.sv
// shared constants and types of the midpoint circle rasterizer
// no dependencies
package mcr_pkg;

  localparam int RADIUS_BITS  = 10;
  localparam int DEC_BITS     = RADIUS_BITS + 3;
  localparam int PIX_BITS     = 12;
  localparam int JOB_DEPTH    = 2;
  localparam int JOB_PTR_BITS = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // one octant point handed from the front to the back
  typedef struct packed {
    logic [RADIUS_BITS-1:0] x;
    logic [RADIUS_BITS-1:0] y;
    logic [RADIUS_BITS-1:0] cx;
    logic [RADIUS_BITS-1:0] cy;
    logic                   done;
  } mcr_job_t;

  typedef struct packed {
    logic job_pop;
    logic at_first;
  } mcr_back_stat_t;

endpackage

>>> sv/mcr_front.sv
// front end: accepts items, runs the decision update and queues step jobs
// depends on mcr_pkg
module mcr_front import mcr_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  logic                   op_i,
  input  logic [RADIUS_BITS-1:0] radius_i,
  input  logic [RADIUS_BITS-1:0] center_x_i,
  input  logic [RADIUS_BITS-1:0] center_y_i,
  output logic                   job_push_o,
  output mcr_job_t               job_o
);

  logic [RADIUS_BITS-1:0] step_x_q, step_x_d;
  logic [RADIUS_BITS-1:0] step_y_q, step_y_d;
  logic [DEC_BITS-1:0]    decision_q, decision_d;
  logic [RADIUS_BITS-1:0] center_x_q, center_x_d;
  logic [RADIUS_BITS-1:0] center_y_q, center_y_d;
  logic                   active_q, active_d;

  logic [DEC_BITS-1:0]    x_w, y_w, r_w, inc_keep, inc_down;
  logic [RADIUS_BITS:0]   x_plus, y_ext;
  logic                   dec_neg, done;

  always_comb begin
    x_w      = DEC_BITS'(step_x_q);
    y_w      = DEC_BITS'(step_y_q);
    r_w      = DEC_BITS'(radius_i);
    dec_neg  = decision_q[DEC_BITS-1];
    inc_keep = (x_w << 2) + DEC_BITS'(6);
    inc_down = ((x_w - y_w) << 2) + DEC_BITS'(10);
    x_plus   = {1'b0, step_x_q} + (RADIUS_BITS+1)'(1);
    y_ext    = {1'b0, step_y_q};
    // y drops by one on the non-negative branch: x+1 > y-1 is x+1 >= y
    done     = dec_neg ? (x_plus > y_ext) : (x_plus >= y_ext);

    job_push_o = accept_i && (op_i == OP_STEP) && active_q;
    job_o.x    = step_x_q;
    job_o.y    = step_y_q;
    job_o.cx   = center_x_q;
    job_o.cy   = center_y_q;
    job_o.done = done;

    step_x_d   = step_x_q;
    step_y_d   = step_y_q;
    decision_d = decision_q;
    center_x_d = center_x_q;
    center_y_d = center_y_q;
    active_d   = active_q;
    if (accept_i && (op_i == OP_START)) begin
      step_x_d   = '0;
      step_y_d   = radius_i;
      decision_d = DEC_BITS'(3) - (r_w << 1);
      center_x_d = center_x_i;
      center_y_d = center_y_i;
      active_d   = 1'b1;
    end else if (job_push_o) begin
      step_x_d   = x_plus[RADIUS_BITS-1:0];
      step_y_d   = dec_neg ? step_y_q : step_y_q - RADIUS_BITS'(1);
      decision_d = decision_q + (dec_neg ? inc_keep : inc_down);
      active_d   = !done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_x_q   <= '0;
      step_y_q   <= '0;
      decision_q <= '0;
      center_x_q <= '0;
      center_y_q <= '0;
      active_q   <= 1'b0;
    end else begin
      step_x_q   <= step_x_d;
      step_y_q   <= step_y_d;
      decision_q <= decision_d;
      center_x_q <= center_x_d;
      center_y_q <= center_y_d;
      active_q   <= active_d;
    end
  end

endmodule

>>> sv/mcr_fifo.sv
// short job queue between front and back
// depends on mcr_pkg
module mcr_fifo import mcr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  mcr_job_t data_i,
  input  logic     pop_i,
  output mcr_job_t data_o,
  output logic     full_o,
  output logic     empty_o
);

  mcr_job_t                mem_q [JOB_DEPTH];
  logic [JOB_PTR_BITS-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [JOB_PTR_BITS:0]   count_q, count_d;
  logic                    do_push, do_pop;

  always_comb begin
    full_o   = (count_q == (JOB_PTR_BITS+1)'(JOB_DEPTH));
    empty_o  = (count_q == '0);
    do_push  = push_i && !full_o;
    do_pop   = pop_i && !empty_o;
    data_o   = mem_q[rd_ptr_q];
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == JOB_PTR_BITS'(JOB_DEPTH-1)) ? '0 : wr_ptr_q + JOB_PTR_BITS'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == JOB_PTR_BITS'(JOB_DEPTH-1)) ? '0 : rd_ptr_q + JOB_PTR_BITS'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + (JOB_PTR_BITS+1)'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - (JOB_PTR_BITS+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

>>> sv/mcr_back.sv
// back end: walks the eight symmetric pixels of a job into the output register
// depends on mcr_pkg
module mcr_back import mcr_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       job_valid_i,
  input  mcr_job_t                   job_i,
  input  logic                       pop_i,
  output logic                       empty_o,
  output logic signed [PIX_BITS-1:0] pixel_x_o,
  output logic signed [PIX_BITS-1:0] pixel_y_o,
  output logic                       last_of_step_o,
  output logic                       circle_done_o,
  output mcr_back_stat_t             stat_o
);

  typedef enum logic [2:0] {
    PH_PX_PY, PH_MX_PY, PH_MX_MY, PH_PX_MY,
    PH_PY_PX, PH_PY_MX, PH_MY_MX, PH_MY_PX
  } phase_e;

  phase_e                       phase_q, phase_d;
  logic                         out_valid_q, out_valid_d;
  logic signed [PIX_BITS-1:0]   pix_x_q, pix_x_d, pix_y_q, pix_y_d;
  logic                         last_q, last_d, done_q, done_d;
  logic [PIX_BITS-1:0]          cx, cy, ox, oy;
  logic                         load;

  always_comb begin
    cx   = PIX_BITS'(job_i.cx);
    cy   = PIX_BITS'(job_i.cy);
    ox   = PIX_BITS'(job_i.x);
    oy   = PIX_BITS'(job_i.y);
    load = job_valid_i && (!out_valid_q || pop_i);

    case (phase_q)
      PH_PX_PY: begin pix_x_d = cx + ox; pix_y_d = cy + oy; end
      PH_MX_PY: begin pix_x_d = cx - ox; pix_y_d = cy + oy; end
      PH_MX_MY: begin pix_x_d = cx - ox; pix_y_d = cy - oy; end
      PH_PX_MY: begin pix_x_d = cx + ox; pix_y_d = cy - oy; end
      PH_PY_PX: begin pix_x_d = cx + oy; pix_y_d = cy + ox; end
      PH_PY_MX: begin pix_x_d = cx + oy; pix_y_d = cy - ox; end
      PH_MY_MX: begin pix_x_d = cx - oy; pix_y_d = cy - ox; end
      PH_MY_PX: begin pix_x_d = cx - oy; pix_y_d = cy + ox; end
      default:  begin pix_x_d = cx;      pix_y_d = cy;      end
    endcase
    last_d = (phase_q == PH_MY_PX);
    done_d = job_i.done;

    phase_d     = load ? phase_e'(phase_q + 3'd1) : phase_q;
    out_valid_d = load ? 1'b1 : (pop_i ? 1'b0 : out_valid_q);

    stat_o.job_pop  = load && last_d;
    stat_o.at_first = (phase_q == PH_PX_PY);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_PX_PY;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      pix_x_q <= pix_x_d;
      pix_y_q <= pix_y_d;
      last_q  <= last_d;
      done_q  <= done_d;
    end
  end

  assign empty_o        = !out_valid_q;
  assign pixel_x_o      = pix_x_q;
  assign pixel_y_o      = pix_y_q;
  assign last_of_step_o = last_q;
  assign circle_done_o  = done_q;

endmodule

>>> sv/midpoint_circle_rasterizer.sv
// midpoint circle rasterizer, top level; needs mcr_pkg, mcr_front, mcr_fifo, mcr_back
// a step item's point goes into the job queue on acceptance and from there into the
//   output register; throughput: one pixel a cycle from the back end while pop is held
//   and a job waits, eight pixels per step; starts give no pixels; full is the two-entry job queue
// reset (rst_ni, async, active low) clears the walk state to idle and empties
//   the job queue and the output register
`include "midpoint_circle_rasterizer_defines.svh"

module midpoint_circle_rasterizer import mcr_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // item side
  input  logic                       push,
  output logic                       full,
  input  logic                       op_i,
  input  logic [RADIUS_BITS-1:0]     radius_i,
  input  logic [RADIUS_BITS-1:0]     center_x_i,
  input  logic [RADIUS_BITS-1:0]     center_y_i,
  // pixel side
  output logic                       empty,
  input  logic                       pop,
  output logic signed [PIX_BITS-1:0] pixel_x_o,
  output logic signed [PIX_BITS-1:0] pixel_y_o,
  output logic                       last_of_step_o,
  output logic                       circle_done_o
);

  logic           accept;
  logic           job_push;
  mcr_job_t       job_in, job_head;
  logic           fifo_full, fifo_empty;
  mcr_back_stat_t back_stat;

  // items are taken whenever the job queue has room; a start also waits for
  // room, which keeps the front simple and costs nothing at the step rate
  assign full   = fifo_full;
  assign accept = push && !fifo_full;

  // front: holds centre, octant point and decision value; a step while a
  // circle is active queues the current point and advances the walk
  mcr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .op_i       (op_i),
    .radius_i   (radius_i),
    .center_x_i (center_x_i),
    .center_y_i (center_y_i),
    .job_push_o (job_push),
    .job_o      (job_in)
  );

  // jobs carry their own centre, so a restart never disturbs queued work
  mcr_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .pop_i   (back_stat.job_pop),
    .data_o  (job_head),
    .full_o  (fifo_full),
    .empty_o (fifo_empty)
  );

  // back: works on the head job in place and releases it with its eighth pixel
  mcr_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (!fifo_empty),
    .job_i          (job_head),
    .pop_i          (pop),
    .empty_o        (empty),
    .pixel_x_o      (pixel_x_o),
    .pixel_y_o      (pixel_y_o),
    .last_of_step_o (last_of_step_o),
    .circle_done_o  (circle_done_o),
    .stat_o         (back_stat)
  );

  // a job leaves the queue only together with its closing pixel
  `MCR_ASSERT(a_pop_with_last, back_stat.job_pop |=> (!empty && last_of_step_o), "bad release")
  // the front never pushes into a full queue
  `MCR_ASSERT_NEVER(a_no_overflow, job_push && fifo_full, "job queue overflow")
  // with no job waiting the back end sits at the first octant
  `MCR_ASSERT(a_idle_phase, fifo_empty |-> back_stat.at_first, "back end mid job")

endmodule
